/* rtl/rmst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// rmst_pkg
// Shared constants, codes and a min helper for the range-minimum segment tree.
// ============================================================================

package rmst_pkg;

    // Number of leaf positions; the node store holds 2*LEAVES entries.
    localparam int unsigned LEAVES = 4096;

    // Node index width (node 1 is the root, leaf p sits at LEAVES+p).
    localparam int unsigned NODE_W = $clog2(2 * LEAVES);
    // Query bounds reach 2*LEAVES, one past the last node.
    localparam int unsigned CNT_W  = NODE_W + 1;

    localparam int unsigned POS_W  = 12;
    localparam int unsigned VAL_W  = 60;

    // Empty-range and reset value of every node.
    localparam logic [VAL_W-1:0] SENTINEL = 60'd1000000000000000000;

    // Item operation codes.
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    function automatic logic [VAL_W-1:0] min_val(
        input logic [VAL_W-1:0] a,
        input logic [VAL_W-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

endpackage

`default_nettype wire

/* rtl/rmst_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// rmst_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ============================================================================

module rmst_ram #(
    parameter int unsigned WIDTH = 60,
    parameter int unsigned DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/range_min_segment_tree_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// range_min_segment_tree_unit
// Bottom-up segment tree of minimums held in one node RAM; point lower
// updates and inclusive range-minimum queries.
// ============================================================================
//
// Channel   Direction  Handshake                  Payload
// -------   ---------  -------------------------  ------------------------------
// in        input      i_in_valid / o_in_ready    i_op, i_position, i_value,
//                                                 i_range_low, i_range_high
// out       output     o_out_valid / i_out_ready  o_minimum (queries only)
//
// Walk: an update reads the old leaf, lowers it, then climbs level by level
//   toward the root: each level reads the sibling and writes the parent
//   in the same cycle, the node RAM's single read port paces the walk.
// A query walks the tree levels, taking an extra step at each level where
//   both bounds take a node; an empty range skips the walk.
//   At most one node read is issued per cycle.
// Reset: a clearing pass writes the sentinel to all 2*LEAVES nodes, one per
//   cycle; o_in_ready stays low until it finishes.
// Stalls: a held result does not block new items; a query that finishes
//   while the output register is still full waits until it drains.
// ============================================================================

module range_min_segment_tree_unit (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // input channel
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic                      i_op,
    input  wire logic [rmst_pkg::POS_W-1:0] i_position,
    input  wire logic [rmst_pkg::VAL_W-1:0] i_value,
    input  wire logic [rmst_pkg::POS_W-1:0] i_range_low,
    input  wire logic [rmst_pkg::POS_W-1:0] i_range_high,
    // output channel
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic      [rmst_pkg::VAL_W-1:0] o_minimum
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_U_LEAF,
        S_U_SIB,
        S_Q_STEP,
        S_Q_DONE
    } t_state;

    localparam logic [rmst_pkg::NODE_W-1:0] CLR_LAST =
        rmst_pkg::NODE_W'(2 * rmst_pkg::LEAVES - 1);
    localparam logic [rmst_pkg::NODE_W-1:0] ROOT = rmst_pkg::NODE_W'(1);

    t_state                        r_state, n_state;
    logic [rmst_pkg::NODE_W-1:0]   r_clr, n_clr;
    logic [rmst_pkg::NODE_W-1:0]   r_node, n_node;
    logic [rmst_pkg::VAL_W-1:0]    r_cur, n_cur;
    logic [rmst_pkg::CNT_W-1:0]    r_left, n_left;
    logic [rmst_pkg::CNT_W-1:0]    r_right, n_right;
    logic [rmst_pkg::VAL_W-1:0]    r_best, n_best;
    logic                          r_rd_pend, n_rd_pend;
    logic                          r_out_valid, n_out_valid;
    logic [rmst_pkg::VAL_W-1:0]    r_min, n_min;

    // node RAM port signals
    logic                          ram_we;
    logic [rmst_pkg::NODE_W-1:0]   ram_waddr;
    logic [rmst_pkg::VAL_W-1:0]    ram_wdata;
    logic [rmst_pkg::NODE_W-1:0]   ram_raddr;
    logic [rmst_pkg::VAL_W-1:0]    ram_rdata;

    // decode of the incoming item
    logic                          in_xfer;
    logic                          pos_ok;
    logic [31:0]                   lo_ext;
    logic [31:0]                   hi_sat;
    logic                          q_empty;
    logic [rmst_pkg::NODE_W-1:0]   leaf_node;
    logic [rmst_pkg::CNT_W-1:0]    q_left;
    logic [rmst_pkg::CNT_W-1:0]    q_right;

    // datapath helpers
    logic [rmst_pkg::VAL_W-1:0]    leaf_new;
    logic [rmst_pkg::VAL_W-1:0]    parent_val;
    logic [rmst_pkg::NODE_W-1:0]   up_node;
    logic [rmst_pkg::CNT_W-1:0]    left_inc;
    logic [rmst_pkg::CNT_W-1:0]    right_dec;
    logic [rmst_pkg::VAL_W-1:0]    best_acc;

    rmst_ram #(
        .WIDTH (rmst_pkg::VAL_W),
        .DEPTH (2 * rmst_pkg::LEAVES)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_minimum   = r_min;

    // Positions past the leaf count are dropped; a high query bound saturates.
    assign pos_ok    = 32'(i_position) < rmst_pkg::LEAVES;
    assign lo_ext    = 32'(i_range_low);
    assign hi_sat    = (32'(i_range_high) >= rmst_pkg::LEAVES) ?
                       (rmst_pkg::LEAVES - 1) : 32'(i_range_high);
    assign q_empty   = (lo_ext >= rmst_pkg::LEAVES) || (lo_ext > hi_sat);
    assign leaf_node = rmst_pkg::NODE_W'(32'(i_position) + rmst_pkg::LEAVES);
    assign q_left    = rmst_pkg::CNT_W'(lo_ext + rmst_pkg::LEAVES);
    assign q_right   = rmst_pkg::CNT_W'(hi_sat + rmst_pkg::LEAVES + 1);

    assign leaf_new   = rmst_pkg::min_val(ram_rdata, r_cur);
    assign parent_val = rmst_pkg::min_val(r_cur, ram_rdata);
    assign up_node    = r_node >> 1;
    assign left_inc   = r_left + rmst_pkg::CNT_W'(1);
    assign right_dec  = r_right - rmst_pkg::CNT_W'(1);

    // A node read issued last cycle lands now; fold it into the running min.
    assign best_acc = r_rd_pend ? rmst_pkg::min_val(r_best, ram_rdata) : r_best;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_node      = r_node;
        n_cur       = r_cur;
        n_left      = r_left;
        n_right     = r_right;
        n_best      = best_acc;
        n_rd_pend   = 1'b0;
        n_out_valid = r_out_valid;
        n_min       = r_min;
        ram_we      = 1'b0;
        ram_waddr   = r_node;
        ram_wdata   = r_cur;
        ram_raddr   = '0;

        // drop the held result once the consumer takes it
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                // sweep the sentinel through every node
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = rmst_pkg::SENTINEL;
                n_clr     = r_clr + rmst_pkg::NODE_W'(1);
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_op == rmst_pkg::OP_QUERY) begin
                        n_best = rmst_pkg::SENTINEL;
                        if (q_empty) begin
                            n_state = S_Q_DONE;
                        end else begin
                            n_left  = q_left;
                            n_right = q_right;
                            n_state = S_Q_STEP;
                        end
                    end else begin
                        n_cur = i_value;
                        if (pos_ok) begin
                            // fetch the old leaf
                            n_node    = leaf_node;
                            ram_raddr = leaf_node;
                            n_state   = S_U_LEAF;
                        end
                    end
                end
            end
            S_U_LEAF: begin
                // lower the leaf, fetch its sibling
                ram_we    = 1'b1;
                ram_waddr = r_node;
                ram_wdata = leaf_new;
                n_cur     = leaf_new;
                ram_raddr = r_node ^ ROOT;
                n_state   = S_U_SIB;
            end
            S_U_SIB: begin
                // write the parent, then advance one level toward the root
                ram_we    = 1'b1;
                ram_waddr = up_node;
                ram_wdata = parent_val;
                n_cur     = parent_val;
                n_node    = up_node;
                if (up_node > ROOT) begin
                    ram_raddr = up_node ^ ROOT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_Q_STEP: begin
                if (r_left < r_right) begin
                    if (r_left[0]) begin
                        // left bound is a right child: take it, step inward
                        ram_raddr = r_left[rmst_pkg::NODE_W-1:0];
                        n_rd_pend = 1'b1;
                        if (r_right[0]) begin
                            n_left = left_inc;
                        end else begin
                            n_left  = left_inc >> 1;
                            n_right = r_right >> 1;
                        end
                    end else if (r_right[0]) begin
                        // right bound sits past a left child: take it
                        ram_raddr = right_dec[rmst_pkg::NODE_W-1:0];
                        n_rd_pend = 1'b1;
                        n_left    = r_left >> 1;
                        n_right   = right_dec >> 1;
                    end else begin
                        n_left  = r_left >> 1;
                        n_right = r_right >> 1;
                    end
                end else begin
                    n_state = S_Q_DONE;
                end
            end
            S_Q_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_min       = r_best;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
        r_node  <= n_node;
        r_cur   <= n_cur;
        r_left  <= n_left;
        r_right <= n_right;
        r_best  <= n_best;
        r_min   <= n_min;
    end

endmodule

`default_nettype wire

/* rtl/rmst_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// rmst_checker
// Port-level checks for the range-minimum segment tree, bound to the top.
// ============================================================================

module rmst_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_ready,
    input wire logic                       i_op,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [rmst_pkg::VAL_W-1:0] o_minimum
);

    // result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_minimum))
        else $error("result dropped or changed while stalled");

    // a result never exceeds the sentinel
    a_out_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_minimum <= rmst_pkg::SENTINEL)
        else $error("result above sentinel");

    // an accepted item moves the unit out of idle, dropping o_in_ready
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready high right after a transfer");

    // an update transfer never produces a result
    a_update_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_op == rmst_pkg::OP_UPDATE) && !o_out_valid
        |=> !o_out_valid)
        else $error("update produced a result");

endmodule

bind range_min_segment_tree_unit rmst_checker u_rmst_checker (.*);

`default_nettype wire

/* sim/tb_range_min_segment_tree_unit.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_range_min_segment_tree_unit
// Self-checking bench for the range-minimum segment tree: a directed table of
// corner items, then random lower/query traffic with random idle bursts on
// both channels. Every query result is compared with a known answer or a behavioral tree model.
// ============================================================================

module tb_range_min_segment_tree_unit;

    import rmst_pkg::*;

    localparam int unsigned DIRECTED_COUNT   = 25;
    localparam int unsigned RANDOM_COUNT     = 1825;
    localparam int unsigned QUIET_TAIL       = 300;   // last items run with no idling
    localparam int unsigned HOLD_AT_ITEM     = 400;   // random item that triggers the long hold
    localparam int unsigned LONG_HOLD_CYCLES = 600;
    localparam int unsigned DRAIN_CYCLES     = 64;
    localparam int unsigned HOT_BASE         = 1000;  // leaves that see repeated lowering
    localparam int unsigned POS_MAX          = (1 << POS_W) - 1;
    localparam longint unsigned RUN_LIMIT_NS = 64'd12_000_000;

    localparam logic [VAL_W-1:0]  VAL_ONES   = {VAL_W{1'b1}};
    localparam logic [VAL_W-1:0]  BELOW_TOP  = SENTINEL - 60'd1;
    localparam logic [POS_W-1:0]  POS_LAST   = POS_MAX[POS_W-1:0];

    typedef struct packed {
        logic             op;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] range_low;
        logic [POS_W-1:0] range_high;
        logic             has_known;
        logic [VAL_W-1:0] known_min;
    } stim_row_t;

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_in_valid   = 1'b0;
    logic             o_in_ready;
    logic             i_op         = OP_UPDATE;
    logic [POS_W-1:0] i_position   = '0;
    logic [VAL_W-1:0] i_value      = '0;
    logic [POS_W-1:0] i_range_low  = '0;
    logic [POS_W-1:0] i_range_high = '0;
    logic             o_out_valid;
    logic             i_out_ready  = 1'b0;
    logic [VAL_W-1:0] o_minimum;

    // Shadow copy of the node store: node 1 is the root, leaf p at LEAVES+p.
    logic [VAL_W-1:0] shadow_nodes [0:2*LEAVES-1];
    logic [VAL_W-1:0] pending_minimums [$];
    int unsigned      mismatch_count = 0;
    bit               bursts_on      = 1'b1;
    bit               hold_request   = 1'b0;

    // Corner items; known_min is filled in where the answer is obvious.
    stim_row_t directed_rows [0:DIRECTED_COUNT-1] = '{
        '{OP_QUERY,  12'd0,    60'd0,        12'd0,    POS_LAST, 1'b1, SENTINEL},
        '{OP_QUERY,  12'd0,    60'd0,        12'd0,    12'd0,    1'b1, SENTINEL},
        '{OP_QUERY,  12'd0,    60'd0,        POS_LAST, POS_LAST, 1'b1, SENTINEL},
        '{OP_QUERY,  12'hABC,  VAL_ONES,     12'd5,    12'd3,    1'b1, SENTINEL},
        '{OP_QUERY,  12'd0,    60'd0,        POS_LAST, 12'd0,    1'b1, SENTINEL},
        '{OP_UPDATE, 12'd0,    60'd0,        12'd0,    12'd0,    1'b0, 60'd0},
        '{OP_QUERY,  12'd0,    60'd0,        12'd0,    POS_LAST, 1'b1, 60'd0},
        '{OP_UPDATE, POS_LAST, VAL_ONES,     12'd0,    12'd0,    1'b0, 60'd0},
        '{OP_QUERY,  12'd0,    60'd0,        POS_LAST, POS_LAST, 1'b1, SENTINEL},
        '{OP_UPDATE, POS_LAST, BELOW_TOP,    12'd0,    12'd0,    1'b0, 60'd0},
        '{OP_QUERY,  12'd0,    60'd0,        POS_LAST, POS_LAST, 1'b1, BELOW_TOP},
        '{OP_QUERY,  12'd0,    60'd0,        12'd1,    POS_LAST, 1'b1, BELOW_TOP},
        '{OP_UPDATE, 12'd2048, 60'd12345,    12'd0,    12'd0,    1'b0, 60'd0},
        '{OP_UPDATE, 12'd2048, 60'd99999,    12'd0,    12'd0,    1'b0, 60'd0},
        '{OP_QUERY,  12'd0,    60'd0,        12'd2048, 12'd2048, 1'b1, 60'd12345},
        '{OP_QUERY,  12'd0,    60'd0,        12'd1,    12'd4094, 1'b1, 60'd12345},
        '{OP_UPDATE, 12'd1,    60'd777,      12'hFFF,  12'h555,  1'b0, 60'd0},
        '{OP_QUERY,  12'd0,    60'd0,        12'd0,    POS_LAST, 1'b1, 60'd0},
        '{OP_QUERY,  12'd0,    60'd0,        12'd1,    12'd2047, 1'b0, 60'd0},
        '{OP_QUERY,  12'd0,    60'd0,        12'd2049, 12'd4094, 1'b1, SENTINEL},
        '{OP_UPDATE, 12'd4094, SENTINEL,     12'd0,    12'd0,    1'b0, 60'd0},
        '{OP_QUERY,  12'hFFF,  60'h0AB_CDEF, 12'd3000, POS_LAST, 1'b1, BELOW_TOP},
        '{OP_UPDATE, 12'd0,    SENTINEL,     12'd0,    12'd0,    1'b0, 60'd0},
        '{OP_QUERY,  12'd0,    60'd0,        12'd0,    12'd1,    1'b1, 60'd0},
        '{OP_QUERY,  12'd0,    60'd0,        12'd2047, 12'd2049, 1'b0, 60'd0}
    };

    range_min_segment_tree_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_position   (i_position),
        .i_value      (i_value),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_minimum    (o_minimum)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("== FAIL ==");
        $finish;
    end

    // Lower one leaf, then rebuild its ancestors from their children.
    function automatic void shadow_lower(input logic [POS_W-1:0] pos,
                                         input logic [VAL_W-1:0] val);
        logic [NODE_W-1:0] node;
        if (32'(pos) >= LEAVES) return;
        node = NODE_W'(32'(pos) + LEAVES);
        if (val < shadow_nodes[node]) shadow_nodes[node] = val;
        while (node > NODE_W'(1)) begin
            shadow_nodes[node >> 1] =
                (shadow_nodes[node] < shadow_nodes[node ^ NODE_W'(1)])
                ? shadow_nodes[node] : shadow_nodes[node ^ NODE_W'(1)];
            node = node >> 1;
        end
    endfunction

    // Bottom-up walk over the half-open node span [lo+LEAVES, hi+LEAVES+1).
    function automatic logic [VAL_W-1:0] shadow_range_min(input logic [POS_W-1:0] lo,
                                                         input logic [POS_W-1:0] hi);
        logic [VAL_W-1:0] best;
        int unsigned      first;
        int unsigned      last;
        int unsigned      left;
        int unsigned      right;
        best  = SENTINEL;
        first = 32'(lo);
        last  = 32'(hi);
        if (first >= LEAVES) return SENTINEL;
        if (last >= LEAVES) last = LEAVES - 1;
        if (first > last) return SENTINEL;
        left  = first + LEAVES;
        right = last + LEAVES + 1;
        while (left < right) begin
            if (left[0]) begin
                if (shadow_nodes[NODE_W'(left)] < best) best = shadow_nodes[NODE_W'(left)];
                left = left + 1;
            end
            if (right[0]) begin
                right = right - 1;
                if (shadow_nodes[NODE_W'(right)] < best) best = shadow_nodes[NODE_W'(right)];
            end
            left  = left >> 1;
            right = right >> 1;
        end
        return best;
    endfunction

    task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                   input logic [VAL_W-1:0] want);
        $display("MISMATCH at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Offer one item, hold it until the transfer, then update the shadow tree or queue the expected minimum.
    task automatic send_item(input stim_row_t row);
        logic [VAL_W-1:0] want;
        if (bursts_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= row.op;
        i_position   <= row.position;
        i_value      <= row.value;
        i_range_low  <= row.range_low;
        i_range_high <= row.range_high;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (row.op == OP_QUERY) begin
            want = row.has_known ? row.known_min
                                 : shadow_range_min(row.range_low, row.range_high);
            pending_minimums.push_back(want);
        end else begin
            shadow_lower(row.position, row.value);
        end
    endtask

    // Result side: random stalls, one long hold on request, steady ready at the end.
    initial begin : result_sink
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end else if (bursts_on && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat (bursts_on ? $urandom_range(1, 16) : 1) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : check_results
        logic [VAL_W-1:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_minimums.size() == 0) begin
                report_mismatch("result with no query pending", o_minimum, '0);
            end else begin
                want = pending_minimums.pop_front();
                if (o_minimum !== want) report_mismatch("minimum", o_minimum, want);
            end
        end
    end

    initial begin : stimulus
        stim_row_t       row;
        longint unsigned wide;
        int unsigned     pick;
        int unsigned     span;
        int unsigned     top;
        bit              tie_high;
        for (int unsigned n = 0; n < 2 * LEAVES; n++) shadow_nodes[NODE_W'(n)] = SENTINEL;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) send_item(directed_rows[k]);

        for (int unsigned n = 0; n < RANDOM_COUNT; n++) begin
            if (n == RANDOM_COUNT - QUIET_TAIL) bursts_on = 1'b0;
            if (n == HOLD_AT_ITEM) hold_request = 1'b1;

            // Start from noise so unused fields carry random bits too.
            wide           = {$urandom(), $urandom()};
            row.value      = wide[VAL_W-1:0];
            row.position   = POS_W'($urandom_range(0, POS_MAX));
            row.range_low  = POS_W'($urandom_range(0, POS_MAX));
            row.range_high = POS_W'($urandom_range(0, POS_MAX));
            row.has_known  = 1'b0;
            row.known_min  = '0;
            pick           = $urandom_range(0, 99);

            if (pick < 50) begin
                row.op = OP_UPDATE;
                if (pick < 20) row.position = POS_W'(HOT_BASE + $urandom_range(0, 63));
                case ($urandom_range(0, 9))
                    0:       ;  // keep the full-width noise value
                    1:       row.value = SENTINEL + VAL_W'($urandom_range(0, 3));
                    2, 3, 4: row.value = VAL_W'($urandom_range(0, 1000));
                    default: row.value = VAL_W'(wide % 64'(SENTINEL));
                endcase
            end else begin
                row.op = OP_QUERY;
                if (pick < 65) row.range_low = POS_W'(HOT_BASE + $urandom_range(0, 63));
                tie_high = 1'b1;
                span     = 0;
                case ($urandom_range(0, 9))
                    0, 1:    tie_high = 1'b0;  // independent bounds, often an empty range
                    2, 3, 4: span = $urandom_range(0, 15);
                    5, 6, 7: span = $urandom_range(0, 300);
                    default: span = $urandom_range(0, POS_MAX);
                endcase
                if (tie_high) begin
                    top = 32'(row.range_low) + span;
                    if (top > POS_MAX) top = POS_MAX;
                    row.range_high = top[POS_W-1:0];
                end
            end
            send_item(row);
        end

        i_in_valid <= 1'b0;
        while (pending_minimums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
